[rtl/core/xkcf_pkg.sv]
// ----------------------------------------------------------------------------
// xkcf_pkg
// Shared types, constants and functions for the XOR key candidate filter:
// field widths, sequencer states, the word unit result and the plaintext
// character set used to drop key candidates.
// ----------------------------------------------------------------------------
package xkcf_pkg;

    // Field widths
    localparam int COL_W        = 6;
    localparam int BYTE_W       = 8;
    localparam int REMAIN_W     = 9;
    localparam int WORD_W       = 64;
    localparam int WORDS_PER_COL = 4;
    localparam int WSEL_W       = 2;
    localparam int BIT_IDX_W    = 6;
    localparam int POP_W        = 7;

    // Stream word widths (fields packed from bit 0, padded to whole bytes)
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 24;

    // Default number of key columns
    localparam int MAX_COLS_DEF = 64;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    // Result of one pass of the shared word unit
    typedef struct packed {
        logic [WORD_W-1:0]    new_word;
        logic [POP_W-1:0]     pop;
        logic                 any;
        logic [BIT_IDX_W-1:0] low_idx;
    } word_res_t;

    // Allowed plaintext characters, one bit per byte value
    function automatic logic [255:0] build_allowed();
        logic [255:0] s;
        logic [7:0]   p;
        s = '0;
        for (int i = 0; i < 256; i++)
        begin
            p = 8'(i);
            s[i] = p inside {[8'h1f:8'h20], [8'h27:8'h2a], [8'h41:8'h5a], [8'h61:8'h7a]};
        end
        return s;
    endfunction

    localparam logic [255:0] ALLOWED_SET = build_allowed();

    // Candidates in word wsel that survive cipher byte cb
    function automatic logic [WORD_W-1:0] keep_mask(
        input logic [BYTE_W-1:0] cb,
        input logic [WSEL_W-1:0] wsel
    );
        logic [WORD_W-1:0] m;
        logic [BYTE_W-1:0] p;
        for (int b = 0; b < WORD_W; b++)
        begin
            p    = {cb[7:6] ^ wsel, cb[5:0] ^ BIT_IDX_W'(b)};
            m[b] = ALLOWED_SET[p];
        end
        return m;
    endfunction

endpackage

[rtl/core/xkcf_word_unit.sv]
// ----------------------------------------------------------------------------
// xkcf_word_unit
// Shared datapath for one 64-bit mask word: clears disallowed candidates,
// counts the survivors and finds the lowest surviving bit.
// ----------------------------------------------------------------------------
module xkcf_word_unit (
    input  logic [xkcf_pkg::WORD_W-1:0] rd_word,
    input  logic [xkcf_pkg::BYTE_W-1:0] cipher_byte,
    input  logic [xkcf_pkg::WSEL_W-1:0] word_sel,
    input  logic                        in_range,
    output xkcf_pkg::word_res_t         res
);

    logic [xkcf_pkg::WORD_W-1:0]    masked;
    logic [1:0]                     s1 [32];
    logic [2:0]                     s2 [16];
    logic [3:0]                     s3 [8];
    logic [4:0]                     s4 [4];
    logic [5:0]                     s5 [2];
    logic [xkcf_pkg::WORD_W-1:0]    v;
    logic [xkcf_pkg::BIT_IDX_W-1:0] idx;

    // Clear candidates; an out-of-range column contributes nothing
    assign masked = in_range
                  ? (rd_word & xkcf_pkg::keep_mask(cipher_byte, word_sel))
                  : '0;

    // Population count as an adder tree
    always_comb
    begin
        for (int i = 0; i < 32; i++)
            s1[i] = 2'(masked[2*i]) + 2'(masked[2*i+1]);
        for (int i = 0; i < 16; i++)
            s2[i] = 3'(s1[2*i]) + 3'(s1[2*i+1]);
        for (int i = 0; i < 8; i++)
            s3[i] = 4'(s2[2*i]) + 4'(s2[2*i+1]);
        for (int i = 0; i < 4; i++)
            s4[i] = 5'(s3[2*i]) + 5'(s3[2*i+1]);
        for (int i = 0; i < 2; i++)
            s5[i] = 6'(s4[2*i]) + 6'(s4[2*i+1]);
    end

    // Lowest set bit by halving search
    always_comb
    begin
        v   = masked;
        idx = '0;
        for (int l = 5; l >= 0; l--)
        begin
            if ((v & ((64'(1) << (1 << l)) - 64'(1))) == '0)
            begin
                idx[l] = 1'b1;
                v      = v >> (1 << l);
            end
        end
    end

    assign res.new_word = masked;
    assign res.pop      = xkcf_pkg::POP_W'(s5[0]) + xkcf_pkg::POP_W'(s5[1]);
    assign res.any      = |masked;
    assign res.low_idx  = idx;

endmodule

[rtl/core/xor_key_candidate_filter_unit.sv]
// ----------------------------------------------------------------------------
// xor_key_candidate_filter_unit
// Keeps a 256-bit key candidate mask per column and prunes it with each
// ciphertext byte; reports survivors, lowest survivor and a solved flag.
// ----------------------------------------------------------------------------
// Sequencing: a word is accepted only in ST_IDLE; ST_RUN walks the
//   four 64-bit mask words of a column one per cycle through the
//   read-modify-write of the mask memory, and ST_HOLD waits for a free output.
// Reset: a clearing pass writes all ones to all 4*MAX_COLS words of the mask
//   memory (256 by default), with s_tready low until it ends.
// ----------------------------------------------------------------------------
module xor_key_candidate_filter_unit #(
    parameter int MAX_COLS = xkcf_pkg::MAX_COLS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // s_tdata: [5:0] column, [13:6] cipher_byte, [15:14] zero
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [xkcf_pkg::IN_TDATA_W-1:0]  s_tdata,
    // m_tdata: [5:0] column_out, [14:6] remaining, [22:15] lowest_key, [23] solved
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [xkcf_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int COL_IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CMP_W_R   = $clog2(MAX_COLS + 1);
    localparam int CMP_W     = (CMP_W_R > xkcf_pkg::COL_W) ? CMP_W_R : xkcf_pkg::COL_W;
    localparam int ADDR_W    = COL_IDX_W + xkcf_pkg::WSEL_W;
    localparam int DEPTH     = MAX_COLS * xkcf_pkg::WORDS_PER_COL;
    localparam logic [xkcf_pkg::WSEL_W-1:0] LAST_WORD = xkcf_pkg::WSEL_W'(xkcf_pkg::WORDS_PER_COL - 1);

    // Input fields
    logic [xkcf_pkg::COL_W-1:0]  in_column;
    logic [xkcf_pkg::BYTE_W-1:0] in_cipher;
    logic [CMP_W-1:0]            col_ext;
    logic                        in_range_in;
    logic [COL_IDX_W-1:0]        row_in;

    // Control
    xkcf_pkg::state_t            state_reg, state_next;
    logic [xkcf_pkg::WSEL_W-1:0] word_reg, word_next;
    logic [ADDR_W-1:0]           clr_addr_reg, clr_addr_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic                        acc;

    // Item context and accumulators
    logic [xkcf_pkg::COL_W-1:0]    col_reg;
    logic [xkcf_pkg::BYTE_W-1:0]   cb_reg;
    logic [COL_IDX_W-1:0]          row_reg;
    logic                          in_range_reg;
    logic [xkcf_pkg::REMAIN_W-1:0] count_reg;
    logic [xkcf_pkg::BYTE_W-1:0]   lowest_reg;
    logic                          found_reg;

    // Output register
    logic [xkcf_pkg::COL_W-1:0]    out_col_reg;
    logic [xkcf_pkg::REMAIN_W-1:0] out_rem_reg;
    logic [xkcf_pkg::BYTE_W-1:0]   out_low_reg;
    logic                          out_solved_reg;

    // Memory
    logic [xkcf_pkg::WORD_W-1:0] mem [DEPTH];
    logic [xkcf_pkg::WORD_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]           rd_addr;
    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    logic [xkcf_pkg::WORD_W-1:0] wr_data;

    // Word unit and step values
    xkcf_pkg::word_res_t           res;
    logic [xkcf_pkg::REMAIN_W-1:0] cnt_sum;
    logic [xkcf_pkg::BYTE_W-1:0]   low_sum;
    logic                          found_sum;
    logic                          out_free;
    logic                          out_load;
    logic [xkcf_pkg::REMAIN_W-1:0] ld_rem;
    logic [xkcf_pkg::BYTE_W-1:0]   ld_low;
    logic                          acc_run;
    logic                          hold_acc;

    // Input unpacking and column range check
    assign in_column   = s_tdata[5:0];
    assign in_cipher   = s_tdata[13:6];
    assign col_ext     = CMP_W'(in_column);
    assign in_range_in = col_ext < CMP_W'(MAX_COLS);
    assign row_in      = in_range_in ? col_ext[COL_IDX_W-1:0] : '0;

    assign s_tready = (state_reg == xkcf_pkg::ST_IDLE);
    assign acc      = s_tvalid & s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Shared word unit
    xkcf_word_unit u_word (
        .rd_word     (rd_data_reg),
        .cipher_byte (cb_reg),
        .word_sel    (word_reg),
        .in_range    (in_range_reg),
        .res         (res)
    );

    // Running totals including the current word
    assign cnt_sum   = count_reg + xkcf_pkg::REMAIN_W'(res.pop);
    assign found_sum = found_reg | res.any;
    assign low_sum   = found_reg ? lowest_reg
                     : (res.any ? {word_reg, res.low_idx} : lowest_reg);

    // Sequencer: next state, memory ports and output load
    always_comb
    begin
        state_next    = state_reg;
        word_next     = word_reg;
        clr_addr_next = clr_addr_reg;
        m_tvalid_next = m_tvalid_reg;
        rd_addr       = {row_reg, word_reg + xkcf_pkg::WSEL_W'(1)};
        wr_en         = 1'b0;
        wr_addr       = {row_reg, word_reg};
        wr_data       = res.new_word;
        out_load      = 1'b0;
        ld_rem        = cnt_sum;
        ld_low        = low_sum;
        acc_run       = 1'b0;
        hold_acc      = 1'b0;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            xkcf_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '1;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                    state_next = xkcf_pkg::ST_IDLE;
            end
            xkcf_pkg::ST_IDLE:
            begin
                rd_addr = {row_in, xkcf_pkg::WSEL_W'(0)};
                if (acc)
                begin
                    word_next  = '0;
                    state_next = xkcf_pkg::ST_RUN;
                end
            end
            xkcf_pkg::ST_RUN:
            begin
                wr_en   = in_range_reg;
                acc_run = 1'b1;
                word_next = word_reg + xkcf_pkg::WSEL_W'(1);
                if (word_reg == LAST_WORD)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = xkcf_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = xkcf_pkg::ST_HOLD;
                    end
                end
            end
            xkcf_pkg::ST_HOLD:
            begin
                hold_acc = 1'b1;
                ld_rem   = count_reg;
                ld_low   = lowest_reg;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = xkcf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = xkcf_pkg::ST_IDLE;
            end
        endcase

        if (out_load)
            m_tvalid_next = 1'b1;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= xkcf_pkg::ST_CLEAR;
            word_reg     <= '0;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            word_reg     <= word_next;
            clr_addr_reg <= clr_addr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Item context and accumulators
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            col_reg      <= in_column;
            cb_reg       <= in_cipher;
            row_reg      <= row_in;
            in_range_reg <= in_range_in;
            count_reg    <= '0;
            lowest_reg   <= '0;
            found_reg    <= 1'b0;
        end
        else if (acc_run)
        begin
            count_reg  <= cnt_sum;
            lowest_reg <= low_sum;
            found_reg  <= found_sum;
        end
        else if (hold_acc)
        begin
            count_reg <= count_reg;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_col_reg    <= col_reg;
            out_rem_reg    <= ld_rem;
            out_low_reg    <= ld_low;
            out_solved_reg <= (ld_rem == xkcf_pkg::REMAIN_W'(1));
        end
    end

    // Mask memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_solved_reg, out_low_reg, out_rem_reg, out_col_reg};

    // Checks
    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> (state_reg == xkcf_pkg::ST_RUN && word_reg == '0))
        else $error("accepted word did not start the mask walk");

    a_solved_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (out_solved_reg == (out_rem_reg == xkcf_pkg::REMAIN_W'(1))))
        else $error("solved flag disagrees with remaining count");

    a_empty_lowest_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && out_rem_reg == '0) |-> (out_low_reg == '0))
        else $error("lowest key nonzero with no candidates");

    a_result_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |->
            ($past(state_reg) == xkcf_pkg::ST_RUN || $past(state_reg) == xkcf_pkg::ST_HOLD))
        else $error("result appeared outside the mask walk");

endmodule
